// ----- rtl/tli_pkg.sv -----
// Package for the table linear interpolator.
// Holds the item types, status codes and sequencer states; depends on nothing.
package tli_pkg;

    localparam int VAL_W = 32;

    localparam logic [1:0] STAT_INSIDE = 2'd0;
    localparam logic [1:0] STAT_EXTRAP = 2'd1;
    localparam logic [1:0] STAT_NOSEG  = 2'd2;
    localparam logic [1:0] STAT_SAT    = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [5:0]        entry_index;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] y_result;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic start;
    } t_md_ctrl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_SEG1,
        S_SEG2,
        S_MATH,
        S_DONE
    } t_state;

endpackage

// ----- rtl/table_linear_interpolator.sv -----
// Top level of the piecewise linear interpolation table.
// Uses tli_pkg and instantiates tli_muldiv.
//
// A write item stores one (x, y) breakpoint. A query item reads
// the table from a synchronous-read memory, one entry per cycle: the
// first and last entries, then a linear scan that ends at the matching
// segment (at most table_length - 1 entries), then the two segment entries.
// The segment arithmetic runs in a shared unit of 33 multiply steps and 66
// divide steps that then flags completion. A query that finds no segment
// skips the arithmetic. The result sits in an output register, so new items
// are taken while it waits. There is no clearing pass; entries must be
// written before a query reaches them.
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [6:0] i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = (AW + 1 > 7) ? AW + 1 : 7;

    t_state r_state, n_state;

    logic [6:0] r_len;
    logic [63:0] r_mem [TABLE_DEPTH];
    logic [63:0] r_rdata;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    logic signed [31:0] r_x, r_x0, r_prev, r_x1, r_y1;
    logic [AW-1:0] r_k, r_seg, last;
    logic [1:0]  r_st;
    logic        r_asc;
    logic        r_neg;
    logic signed [31:0] r_res_y;
    logic [1:0]  r_res_st;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [LW-1:0] len_ext, len_use;
    logic          len_bad;
    logic signed [31:0] cur_x, cur_y;
    logic          accept, is_query;
    logic          flat, ext_lo, ext_hi, hit, out_free;
    logic [1:0]    hi_st;
    logic signed [32:0] dx, dy, dd;
    logic [32:0]   mag_dx, mag_dy, mag_dd;
    logic          md_done;
    logic [65:0]   md_quot;
    t_md_ctrl      md_ctrl;

    logic signed [35:0] q_s, sum;
    logic               q_big;
    logic signed [31:0] fin_y;
    logic [1:0]         fin_st;

    // Effective length and last index.
    assign len_ext = LW'(r_len);
    assign len_use = (len_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : len_ext;
    assign len_bad = len_ext < LW'(2);
    assign last    = AW'(len_use - LW'(1));

    assign accept   = i_in_valid && o_in_ready;
    assign is_query = i_in_item.op == OP_QUERY;
    assign cur_x    = r_rdata[63:32];
    assign cur_y    = r_rdata[31:0];
    assign out_free = !r_out_valid || i_out_ready;

    // Segment choice once first and last x are known.
    assign flat   = r_x0 == cur_x;
    assign ext_lo = (r_x0 < cur_x) ? (r_x < r_x0) : (r_x > r_x0);
    assign ext_hi = (r_x0 < cur_x) ? (r_x >= cur_x) : (r_x <= cur_x);
    assign hi_st  = (r_x == cur_x) ? STAT_INSIDE : STAT_EXTRAP;
    assign hit    = r_asc ? (r_prev <= r_x && r_x < cur_x)
                          : (r_prev >= r_x && r_x > cur_x);

    // Segment differences from the two stored entries.
    assign dx = 33'(r_x) - 33'(r_x1);
    assign dy = 33'(r_y1) - 33'(cur_y);
    assign dd = 33'(r_x1) - 33'(cur_x);
    assign mag_dx = dx[32] ? 33'(-dx) : dx;
    assign mag_dy = dy[32] ? 33'(-dy) : dy;
    assign mag_dd = dd[32] ? 33'(-dd) : dd;

    // Final add and saturation.
    assign q_big = |md_quot[65:34];
    assign q_s   = r_neg ? -$signed({2'b00, md_quot[33:0]}) : $signed({2'b00, md_quot[33:0]});
    assign sum   = q_s + 36'(r_y1);
    always_comb begin
        fin_y  = sum[31:0];
        fin_st = r_st;
        if (q_big) begin
            fin_y  = r_neg ? 32'sh80000000 : 32'sh7fffffff;
            fin_st = STAT_SAT;
        end else if (sum > 36'sh07fffffff) begin
            fin_y  = 32'sh7fffffff;
            fin_st = STAT_SAT;
        end else if (sum < -36'sh080000000) begin
            fin_y  = 32'sh80000000;
            fin_st = STAT_SAT;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_query) n_state = len_bad ? S_DONE : S_FIRST;
            end
            S_FIRST: n_state = S_LAST;
            S_LAST: begin
                if (flat) n_state = S_DONE;
                else if (ext_lo || ext_hi) n_state = S_SEG1;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit) n_state = S_SEG1;
                else if (r_k == last) n_state = S_DONE;
            end
            S_SEG1: n_state = S_SEG2;
            S_SEG2: n_state = (dd == 33'sd0) ? S_DONE : S_MATH;
            S_MATH: if (md_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs: ready, memory address and write, unit start.
    always_comb begin
        o_in_ready    = 1'b0;
        mem_we        = 1'b0;
        rd_addr       = '0;
        md_ctrl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                mem_we = accept && !is_query &&
                         (32'(i_in_item.entry_index) < 32'(TABLE_DEPTH));
            end
            S_FIRST: rd_addr = last;
            S_LAST: begin
                if (ext_lo) rd_addr = '0;
                else if (ext_hi) rd_addr = AW'(last - AW'(1));
                else rd_addr = AW'(1);
            end
            S_SCAN: rd_addr = hit ? AW'(r_k - AW'(1)) : AW'(r_k + AW'(1));
            S_SEG1: rd_addr = AW'(r_seg + AW'(1));
            S_SEG2: md_ctrl.start = dd != 33'sd0;
            default: rd_addr = '0;
        endcase
    end

    // Breakpoint memory, x in the upper half of each word.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(i_in_item.entry_index)] <= {i_in_item.x_value, i_in_item.y_value};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= 7'd2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_len <= i_cfg_data;
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x      <= i_in_item.x_value;
                r_res_y  <= '0;
                r_res_st <= STAT_NOSEG;
            end
            S_FIRST: begin
                r_x0   <= cur_x;
                r_prev <= cur_x;
            end
            S_LAST: begin
                r_asc <= r_x0 < cur_x;
                r_k   <= AW'(1);
                if (ext_lo) begin
                    r_seg <= '0;
                    r_st  <= STAT_EXTRAP;
                end else begin
                    r_seg <= AW'(last - AW'(1));
                    r_st  <= ext_hi ? hi_st : STAT_INSIDE;
                end
            end
            S_SCAN: begin
                r_prev <= cur_x;
                r_k    <= AW'(r_k + AW'(1));
                r_seg  <= AW'(r_k - AW'(1));
            end
            S_SEG1: begin
                r_x1 <= cur_x;
                r_y1 <= cur_y;
            end
            S_SEG2: begin
                r_neg <= (dx[32] != dy[32]) != dd[32];
            end
            S_MATH: begin
                if (md_done) begin
                    r_res_y  <= fin_y;
                    r_res_st <= fin_st;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_item.y_result <= r_res_y;
                    r_out_item.status   <= r_res_st;
                end
            end
            default: r_x <= r_x;
        endcase
    end

    tli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (md_ctrl),
        .i_a     (mag_dx),
        .i_b     (mag_dy),
        .i_d     (mag_dd),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // A result with no valid segment carries a zero value.
    a_noseg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == STAT_NOSEG |-> o_out_item.y_result == 32'sd0)
        else $error("no-segment result with nonzero value");
    // The arithmetic unit finishing moves the sequencer to result delivery.
    a_math_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MATH && md_done |=> r_state == S_DONE)
        else $error("finished arithmetic not delivered");
    // A pending result is never overwritten by the next one.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && o_out_valid && !i_out_ready |=> r_state == S_DONE)
        else $error("result delivered over a waiting one");
    // The unit only starts while the sequencer sits before the math state.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_ctrl.start |-> r_state == S_SEG2)
        else $error("arithmetic started out of sequence");
`endif

endmodule

// ----- rtl/tli_muldiv.sv -----
// Sequential unsigned multiply then divide: q = (a * b) / d, truncated.
// Uses tli_pkg for the control struct; shift-add multiply, restoring divide.
module tli_muldiv
    import tli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_md_ctrl    i_ctrl,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    input  logic [32:0] i_d,
    output logic        o_done,
    output logic [65:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_div, n_div;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [66:0] r_acc, n_acc;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_a, r_d;

    logic [33:0] mul_sum;
    logic [33:0] div_try;
    logic        div_ge;

    // One add per cycle for each multiply or divide step.
    assign mul_sum = r_acc[66:33] + (r_acc[0] ? {1'b0, r_a} : 34'd0);
    assign div_try = {r_rem, r_acc[65]};
    assign div_ge  = div_try >= {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_acc  = r_acc;
        n_rem  = r_rem;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_div  = 1'b0;
            n_cnt  = 7'd33;
            n_acc  = {34'd0, i_b};
        end else if (r_busy && !r_div) begin
            n_acc = {1'b0, mul_sum, r_acc[32:1]};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_div = 1'b1;
                n_cnt = 7'd66;
                n_rem = 33'd0;
            end
        end else if (r_busy) begin
            n_rem = div_ge ? 33'(div_try - {1'b0, r_d}) : div_try[32:0];
            n_acc = {1'b0, r_acc[64:0], div_ge};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_div  <= n_div;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_rem <= n_rem;
        if (i_ctrl.start) begin
            r_a <= i_a;
            r_d <= i_d;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc[65:0];

endmodule

// ----- sim/tli_checker.sv -----
// Checker for the table linear interpolator: mirrors the breakpoint table,
// predicts every query result and compares it with what the block returns.
// Depends on tli_pkg for the item types and status codes.
`timescale 1ns / 100ps

module tli_checker
    import tli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -VMAX - 1;

    // Shadow copy of the breakpoint table and the length register.
    longint     bp_x [64];
    longint     bp_y [64];
    logic [6:0] tbl_len;
    t_out_item  expected_results [$];

    function automatic t_out_item eval_line(longint xq, int seg, logic [1:0] st_in);
        t_out_item res;
        longint dx, dy, dd;
        logic [127:0] adx, ady, add, prod, quo;
        logic signed [129:0] q, r;
        logic neg;
        dx = xq - bp_x[seg];
        dy = bp_y[seg] - bp_y[seg + 1];
        dd = bp_x[seg] - bp_x[seg + 1];
        if (dd == 0) begin
            res.y_result = '0;
            res.status = STAT_NOSEG;
            return res;
        end
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        add = (dd < 0) ? -dd : dd;
        prod = adx * ady;
        quo = prod / add;
        neg = ((dx < 0) != (dy < 0)) != (dd < 0);
        q = $signed({2'b00, quo});
        if (neg) q = -q;
        r = q + bp_y[seg];
        res.status = st_in;
        if (r > VMAX) begin
            res.y_result = 32'h7fffffff;
            res.status = STAT_SAT;
        end else if (r < VMIN) begin
            res.y_result = 32'h80000000;
            res.status = STAT_SAT;
        end else begin
            res.y_result = r[31:0];
        end
        return res;
    endfunction

    // Segment search for an ascending or descending table, then the line fit.
    function automatic t_out_item interp(logic signed [31:0] xv);
        t_out_item res;
        int n, last, seg;
        longint x, fx, lx;
        logic [1:0] st;
        bit found;
        res.y_result = '0;
        res.status = STAT_NOSEG;
        found = 0;
        seg = 0;
        st = STAT_INSIDE;
        if (tbl_len < 2) return res;
        n = (tbl_len > 64) ? 64 : int'(tbl_len);
        last = n - 1;
        x = xv;
        fx = bp_x[0];
        lx = bp_x[last];
        if (fx < lx) begin
            if (x < fx) begin
                seg = 0; st = STAT_EXTRAP; found = 1;
            end else if (x >= lx) begin
                seg = last - 1; st = (x > lx) ? STAT_EXTRAP : STAT_INSIDE; found = 1;
            end else begin
                for (int i = 0; i < last && !found; i++)
                    if (bp_x[i] <= x && x < bp_x[i + 1]) begin
                        seg = i; found = 1;
                    end
            end
        end else if (fx > lx) begin
            if (x > fx) begin
                seg = 0; st = STAT_EXTRAP; found = 1;
            end else if (x <= lx) begin
                seg = last - 1; st = (x < lx) ? STAT_EXTRAP : STAT_INSIDE; found = 1;
            end else begin
                for (int i = 0; i < last && !found; i++)
                    if (bp_x[i] >= x && x > bp_x[i + 1]) begin
                        seg = i; found = 1;
                    end
            end
        end
        if (!found) return res;
        return eval_line(x, seg, st);
    endfunction

    // Track accepted items on both channels and the register writes.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            tbl_len <= 7'd2;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) tbl_len <= i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.op == OP_WRITE) begin
                    bp_x[i_in_item.entry_index] = i_in_item.x_value;
                    bp_y[i_in_item.entry_index] = i_in_item.y_value;
                end else begin
                    expected_results.push_back(interp(i_in_item.x_value));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no query pending");
                    errs++;
                end else begin
                    exp_item = expected_results.pop_front();
                    if (i_out_item.y_result !== exp_item.y_result) begin
                        $error("y_result: expected %0d, got %0d",
                            exp_item.y_result, i_out_item.y_result);
                        errs++;
                    end
                    if (i_out_item.status !== exp_item.status) begin
                        $error("status: expected %0d, got %0d",
                            exp_item.status, i_out_item.status);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- sim/table_linear_interpolator_tb.sv -----
// Testbench top for the table linear interpolator: clock, reset, stimulus
// and verdict. Depends on tli_pkg, the block and tli_checker.
`timescale 1ns / 100ps

module table_linear_interpolator_tb;
    import tli_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 250;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we;
    logic [6:0] cfg_data;
    int         fail_count;
    int         pending;

    int burst_left;
    int query_count;
    int phase_count;
    int idle_cycles = 0;
    longint bp_vals [64];

    table_linear_interpolator #(.TABLE_DEPTH(64)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    tli_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stall pattern: the mode is redrawn each time stall_tick wraps to zero.
    int stall_mode = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (stall_tick == 0) stall_mode <= $urandom_range(0, 3);
        stall_tick <= (stall_tick + 1) % 64;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= (stall_tick[2:0] != 3'd0);
        endcase
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one item in bursts with random gaps between them.
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (!in_ready);
        burst_left--;
        if (it.op == OP_QUERY) query_count++;
    endtask

    task automatic write_entry(input int idx, input longint xv, input longint yv);
        t_in_item it;
        it.op = OP_WRITE;
        it.entry_index = idx[5:0];
        it.x_value = xv[31:0];
        it.y_value = yv[31:0];
        send_item(it);
    endtask

    task automatic query_at(input longint xv);
        t_in_item it;
        it.op = OP_QUERY;
        it.entry_index = $urandom;
        it.x_value = xv[31:0];
        it.y_value = $urandom;
        send_item(it);
    endtask

    // Waits until every result has come and the block has settled.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [6:0] len);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_data <= len;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scaled_value(int bits);
        int raw;
        raw = $urandom;
        return longint'(raw >>> (31 - bits));
    endfunction

    // One phase: a new length, a table of a random shape, then mixed items.
    task automatic run_phase(input logic [6:0] len, input int n_items);
        int n, shape, bits, k, pick;
        longint v [$];
        longint xq;
        set_length(len);
        phase_count++;
        n = (len > 64) ? 64 : ((len < 2) ? 2 : int'(len));
        shape = $urandom_range(0, 4);
        bits = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(6, 28);
        for (int i = 0; i < n; i++) v.push_back(scaled_value(bits));
        if (shape == 0 || shape == 3) v.sort();
        if (shape == 1) v.rsort();
        if (shape == 2) v[n - 1] = v[0];
        if (shape == 3) begin
            k = $urandom_range(0, n - 2);
            v[k + 1] = v[k];
        end
        for (int i = 0; i < n; i++) begin
            bp_vals[i] = v[i];
            write_entry(i, v[i], scaled_value($urandom_range(4, 31)));
        end
        for (int j = 0; j < n_items; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                k = $urandom_range(0, 63);
                if (k >= n) write_entry(k, scaled_value(bits), $urandom);
                else begin
                    bp_vals[k] = scaled_value(bits);
                    write_entry(k, bp_vals[k], scaled_value($urandom_range(4, 31)));
                end
            end else begin
                pick = $urandom_range(0, 99);
                k = $urandom_range(0, n - 1);
                if (pick < 40) xq = clamp32(bp_vals[k] + $urandom_range(0, 6) - 3);
                else if (pick < 50) xq = bp_vals[k];
                else if (pick < 55) xq = -64'sd2147483648;
                else if (pick < 60) xq = 64'sd2147483647;
                else if (pick < 70) xq = longint'(int'($urandom));
                else xq = scaled_value(bits);
                query_at(xq);
            end
        end
    endtask

    initial begin
        logic [6:0] lens [$];
        int total;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        burst_left = 0;
        query_count = 0;
        phase_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset length of two entries.
        write_entry(0, -32'sd65536, 32'sd131072);
        write_entry(1, 32'sd65536, -32'sd131072);
        query_at(0);
        query_at(-32'sd65536);
        query_at(32'sd65536);
        query_at(-32'sd200000);
        query_at(32'sd200000);
        query_at(-64'sd2147483648);
        query_at(64'sd2147483647);
        // Steep segment that saturates at both ends.
        write_entry(1, -32'sd65535, 64'sd2147483647);
        write_entry(0, -32'sd65536, -64'sd2147483648);
        query_at(64'sd2147483647);
        query_at(-64'sd2147483648);
        // Descending table, last breakpoint exactly, then a flat table.
        write_entry(0, 64'sd2147483647, 32'sd5);
        write_entry(1, -64'sd2147483648, -32'sd5);
        query_at(-64'sd2147483648);
        query_at(32'sd1);
        write_entry(1, 64'sd2147483647, 32'sd7);
        query_at(32'sd3);
        write_entry(63, -64'sd2147483648, 64'sd2147483647);

        // Random phases through the length extremes and out-of-range values.
        lens = '{7'd64, 7'd127, 7'd0, 7'd3, 7'd1, 7'd2, 7'd17, 7'd64};
        total = 0;
        while (total < 1750) begin
            logic [6:0] len;
            if (lens.size() != 0) len = lens.pop_front();
            else len = ($urandom_range(0, 4) == 0) ? 7'd64 : $urandom_range(2, 24);
            run_phase(len, 110);
            total += 110 + ((len > 64) ? 64 : ((len < 2) ? 2 : int'(len)));
        end

        wait_quiet();
        $display("Covered %0d table settings and %0d queries with bursty input",
            phase_count, query_count);
        $display("and a stalling receiver.");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tli_pkg.sv
rtl/tli_muldiv.sv
rtl/table_linear_interpolator.sv
sim/tli_checker.sv
sim/table_linear_interpolator_tb.sv
